FILE: rtl/core/flptw_pkg.sv
// Shared types, codes and helpers for the four-level page table walker.
`timescale 1ns / 1ps
`default_nettype none
package flptw_pkg;

  localparam int IDX_W   = 9;
  localparam int ENTRY_W = 64;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int FLAGS_W = 12;
  localparam int BASE_W  = 40;
  localparam int ROOT_W  = 4;
  localparam int PN_W    = ENTRY_W - 12;

  // Request kinds
  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_UNMAP = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FLOOR   = 3'd1;
  localparam logic [2:0] ST_HUGE    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_OUTSIDE = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROOT_PAGE  = 2'd0;
  localparam logic [1:0] CFG_STORE_BASE = 2'd1;
  localparam logic [1:0] CFG_MAP_FLOOR  = 2'd2;

  // Configuration reset values
  localparam logic [ROOT_W-1:0] ROOT_RESET  = 4'd0;
  localparam logic [BASE_W-1:0] BASE_RESET  = 40'd1024;
  localparam logic [VA_W-1:0]   FLOOR_RESET = 48'h40_0000;

  // Walk levels: top table, second table, directory, leaf table
  localparam logic [1:0] LEVEL_TOP  = 2'd0;
  localparam logic [1:0] LEVEL_MID  = 2'd1;
  localparam logic [1:0] LEVEL_DIR  = 2'd2;
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  localparam int PRESENT_BIT = 0;
  localparam int HUGE_BIT    = 7;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture request and start at the root page
    logic       rd;        // read entry of current page at level index
    logic       wr_alloc;  // write new table pointer and allocate a page
    logic       wr_leaf;   // write leaf entry (map value or zero)
    logic       adv;       // step to the page the read entry names
    logic       clr_wr;    // clearing sweep write
    logic [1:0] lvl;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       below_floor;
    logic       root_out;
    logic       present;
    logic       huge;
    logic       outside;
    logic       full;
    logic       clr_last;
  } dp_stat_t;

  // Table index of a virtual address at a walk level
  function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
                                              input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LEVEL_TOP: idx = va[47:39];
      LEVEL_MID: idx = va[38:30];
      LEVEL_DIR: idx = va[29:21];
      default:   idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/flptw_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module flptw_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word a cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/flptw_datapath.sv
// Datapath: request and config registers, table store, entry decode, allocator.
`timescale 1ns / 1ps
`default_nettype none
module flptw_datapath #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [47:0]           cfg_data,
  // request payload
  input  wire logic [119:0]          req_data,
  input  wire flptw_pkg::dp_cmd_t    cmd,
  output flptw_pkg::dp_stat_t        stat
);

  localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
  localparam int DEPTH  = TABLE_PAGES * 512;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MEM_W  = flptw_pkg::ENTRY_W + 1;

  // Configuration registers
  logic [flptw_pkg::ROOT_W-1:0] root_page;
  logic [flptw_pkg::BASE_W-1:0] store_base_page;
  logic [flptw_pkg::VA_W-1:0]   map_floor;

  // Request registers
  logic [1:0]                    op;
  logic [flptw_pkg::VA_W-1:0]    va;
  logic [flptw_pkg::PA_W-1:0]    pa;
  logic [flptw_pkg::FLAGS_W-1:0] flags;

  // Walk state
  logic [PAGE_W-1:0]      pg;
  logic [PAGE_W-1:0]      rd_page;
  logic [CNT_W-1:0]       next_table_page;
  logic [TABLE_PAGES-1:0] gen;
  logic [ADDR_W-1:0]      clr_addr;

  // Store port
  logic                   mem_en;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [MEM_W-1:0]       mem_wdata;
  logic [MEM_W-1:0]       mem_rdata;

  // Entry decode
  logic [flptw_pkg::ENTRY_W-1:0] ent;
  logic [flptw_pkg::PN_W-1:0]    pn;
  logic [flptw_pkg::PN_W-1:0]    base_ext;
  logic [flptw_pkg::PN_W-1:0]    pn_off;
  logic                          pn_below;
  logic [PAGE_W-1:0]             alloc_pg;
  logic [flptw_pkg::BASE_W:0]    alloc_pn;
  logic                          alloc_tag;
  logic [flptw_pkg::ENTRY_W-1:0] alloc_ent;
  logic [flptw_pkg::ENTRY_W-1:0] leaf_ent;
  logic [ADDR_W-1:0]             walk_addr;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_page       <= flptw_pkg::ROOT_RESET;
      store_base_page <= flptw_pkg::BASE_RESET;
      map_floor       <= flptw_pkg::FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flptw_pkg::CFG_ROOT_PAGE:  root_page <= cfg_data[flptw_pkg::ROOT_W-1:0];
        flptw_pkg::CFG_STORE_BASE: store_base_page <= cfg_data[flptw_pkg::BASE_W-1:0];
        flptw_pkg::CFG_MAP_FLOOR:  map_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req_data[1:0];
      va    <= req_data[49:2];
      pa    <= req_data[101:50];
      flags <= req_data[113:102];
    end
  end

  // Decode the entry just read; a stale tag reads as a cleared entry
  assign ent      = (mem_rdata[MEM_W-1] == gen[rd_page]) ?
                    mem_rdata[flptw_pkg::ENTRY_W-1:0] : '0;
  assign pn       = ent[flptw_pkg::ENTRY_W-1:12];
  assign base_ext = flptw_pkg::PN_W'(store_base_page);
  assign pn_below = pn < base_ext;
  assign pn_off   = pn - base_ext;

  // Allocation: new page number and pointer entry
  assign alloc_pg  = next_table_page[PAGE_W-1:0];
  assign alloc_pn  = {1'b0, store_base_page} + (flptw_pkg::BASE_W + 1)'(alloc_pg);
  assign alloc_ent = {11'b0, alloc_pn, flags};
  assign alloc_tag = gen[pg] ^ (pg == alloc_pg);
  assign leaf_ent  = (op == flptw_pkg::OP_MAP) ?
                     ({12'b0, pa} | {52'b0, flags}) : '0;

  assign walk_addr = ADDR_W'({pg, flptw_pkg::idx_of(va, cmd.lvl)});

  // Store port selection
  always_comb begin
    mem_en    = cmd.clr_wr | cmd.rd | cmd.wr_alloc | cmd.wr_leaf;
    mem_we    = cmd.clr_wr | cmd.wr_alloc | cmd.wr_leaf;
    mem_addr  = walk_addr;
    mem_wdata = {gen[pg], leaf_ent};
    if (cmd.clr_wr) begin
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (cmd.wr_alloc) begin
      mem_wdata = {alloc_tag, alloc_ent};
    end
  end

  flptw_ram #(
    .WIDTH(MEM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Advance sweep address, allocator and page generations; the walk page follows
  always_ff @(posedge clk) begin
    if (rst) begin
      next_table_page <= CNT_W'(1);
      gen             <= '0;
      clr_addr        <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.wr_alloc) begin
        next_table_page     <= next_table_page + CNT_W'(1);
        gen[alloc_pg]       <= ~gen[alloc_pg];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pg <= PAGE_W'(32'(root_page));
    end else if (cmd.wr_alloc) begin
      pg <= alloc_pg;
    end else if (cmd.adv) begin
      pg <= pn_off[PAGE_W-1:0];
    end
    if (cmd.rd) begin
      rd_page <= pg;
    end
  end

  // Report to the controller
  always_comb begin
    stat.op          = op;
    stat.below_floor = va < map_floor;
    stat.root_out    = 32'(root_page) >= TABLE_PAGES;
    stat.present     = ent[flptw_pkg::PRESENT_BIT];
    stat.huge        = ent[flptw_pkg::HUGE_BIT];
    stat.outside     = pn_below || (pn_off >= flptw_pkg::PN_W'(TABLE_PAGES));
    stat.full        = 32'(next_table_page) >= TABLE_PAGES;
    stat.clr_last    = clr_addr == ADDR_W'(DEPTH - 1);
  end

endmodule
`default_nettype wire

FILE: rtl/core/flptw_ctrl.sv
// Controller: sequences store clearing, table walk, allocation and result.
`timescale 1ns / 1ps
`default_nettype none
module flptw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [7:0]              m_tdata,   // is_mapped, status[3:1], zero pad
  input  wire flptw_pkg::dp_stat_t stat,
  output flptw_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD,
    S_EV,
    S_LEAF,
    S_DONE
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] lvl;
  logic [1:0] lvl_next;
  logic [2:0] res_status;
  logic [2:0] res_status_next;
  logic       res_mapped;
  logic       res_mapped_next;
  logic       is_map;
  logic       is_query;
  logic       go_next;

  assign is_map   = stat.op == flptw_pkg::OP_MAP;
  assign is_query = stat.op == flptw_pkg::OP_QUERY;
  assign s_tready = state == S_IDLE;

  // Decide commands and next state
  always_comb begin
    state_next      = state;
    lvl_next        = lvl;
    res_status_next = res_status;
    res_mapped_next = res_mapped;
    go_next         = 1'b0;
    cmd             = '0;
    cmd.lvl         = lvl;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        lvl_next        = flptw_pkg::LEVEL_TOP;
        res_mapped_next = 1'b0;
        res_status_next = flptw_pkg::ST_DONE;
        state_next      = S_RD;
        case (stat.op) inside
          flptw_pkg::OP_MAP: begin
            if (stat.below_floor) begin
              res_status_next = flptw_pkg::ST_FLOOR;
              state_next      = S_DONE;
            end else if (stat.root_out) begin
              res_status_next = flptw_pkg::ST_OUTSIDE;
              state_next      = S_DONE;
            end
          end
          flptw_pkg::OP_QUERY, flptw_pkg::OP_UNMAP: begin
            if (stat.root_out) begin
              res_status_next = flptw_pkg::ST_OUTSIDE;
              state_next      = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        state_next = S_DONE;
        if (lvl == flptw_pkg::LEVEL_LEAF) begin
          res_mapped_next = stat.present;
        end else if (lvl == flptw_pkg::LEVEL_DIR && stat.huge) begin
          if (is_query) begin
            res_mapped_next = 1'b1;
          end else begin
            res_status_next = flptw_pkg::ST_HUGE;
          end
        end else if (!stat.present) begin
          if (!is_map) begin
            res_status_next = is_query ? flptw_pkg::ST_DONE : flptw_pkg::ST_ABSENT;
          end else if (stat.full) begin
            res_status_next = flptw_pkg::ST_FULL;
          end else begin
            cmd.wr_alloc = 1'b1;
            go_next      = 1'b1;
          end
        end else if (stat.outside) begin
          res_status_next = flptw_pkg::ST_OUTSIDE;
        end else begin
          cmd.adv = 1'b1;
          go_next = 1'b1;
        end
        // Step down one level; the leaf is read for query, written otherwise
        if (go_next) begin
          lvl_next = lvl + 2'd1;
          if (lvl == flptw_pkg::LEVEL_DIR && !is_query) begin
            state_next = S_LEAF;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_LEAF: begin
        cmd.wr_leaf = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state, walk level and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      lvl      <= flptw_pkg::LEVEL_TOP;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'b0, res_status, res_mapped};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    res_status <= res_status_next;
    res_mapped <= res_mapped_next;
  end

endmodule
`default_nettype wire

FILE: rtl/core/four_level_page_table_walker_core.sv
// Top level of the four-level page table walker.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  s_      | in        | s_tvalid / s_tready  | s_tdata: op, vaddr, paddr,
//          |           |                      |   entry_flags
//  m_      | out       | m_tvalid / m_tready  | m_tdata: is_mapped, status
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request passes from the idle state that takes it through the floor/root check,
// a dependent read and decode per table level through the single store port, a
// leaf write on map and unmap, and a result handoff.
// After reset the store is swept clean with s_tready low; configuration writes
// are taken at any time.
// A new request is taken while an earlier result still waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_table_walker_core #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [119:0] s_tdata,   // op[1:0], vaddr[49:2], paddr[101:50],
                                       // entry_flags[113:102], zero pad
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,   // is_mapped[0], status[3:1], zero pad
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);

  flptw_pkg::dp_cmd_t  cmd;
  flptw_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  flptw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .stat    (stat),
    .cmd     (cmd)
  );

  flptw_datapath #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_data (s_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
`default_nettype wire

FILE: rtl/core/flptw_checker.sv
// Port-level checks for the page table walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module flptw_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [7:0]   m_tdata
);

  // A held result does not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Status is a defined code and padding is zero
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:1] <= 3'd5) && (m_tdata[7:4] == 4'd0))
    else $error("undefined status or nonzero pad");

  // A mapped answer always comes with done status
  a_mapped_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[3:1] == 3'd0)
    else $error("is_mapped set with error status");

  // One request at a time: the input closes right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken during a walk");

endmodule

bind four_level_page_table_walker_core flptw_checker u_flptw_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire
